// File: rtl/urhr_pkg.sv
package urhr_pkg;

    // Field widths of the channel words
    localparam int OPCODE_W     = 2;
    localparam int SNAP_FIELD_W = 32;
    localparam int COUNT_W      = 5;

    typedef logic [OPCODE_W-1:0] t_opcode;

    // Operation codes
    localparam t_opcode OP_PUSH = 2'd0;
    localparam t_opcode OP_UNDO = 2'd1;
    localparam t_opcode OP_REDO = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } t_cmd;

endpackage

// File: rtl/urhr_ifs.sv
interface urhr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [urhr_pkg::OPCODE_W-1:0]        opcode;
    logic [urhr_pkg::SNAP_FIELD_W-1:0]    snapshot_in;

    modport source (output valid, output opcode, output snapshot_in, input ready);
    modport sink   (input valid, input opcode, input snapshot_in, output ready);
endinterface

interface urhr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic [urhr_pkg::SNAP_FIELD_W-1:0]    snapshot_out;
    logic [urhr_pkg::COUNT_W-1:0]         undo_count;
    logic [urhr_pkg::COUNT_W-1:0]         redo_count;

    modport source (output valid, output accepted, output snapshot_out,
                    output undo_count, output redo_count, input ready);
    modport sink   (input valid, input accepted, input snapshot_out,
                    input undo_count, input redo_count, output ready);
endinterface

// File: rtl/urhr_ctrl.sv
module urhr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output urhr_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FIN
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   can_commit;
    logic   take_in;

    // Commit only when the output register is free or being emptied
    assign can_commit = !r_out_valid || i_out_ready;
    assign take_in    = i_in_valid && r_in_ready;

    assign o_cmd.capture = take_in;
    assign o_cmd.read    = (r_state == ST_READ);
    assign o_cmd.commit  = (r_state == ST_FIN) && can_commit;

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // Sequence one word through read and commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (take_in) begin
                        r_state    <= ST_READ;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_READ: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (can_commit) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase

            // Hold the result word until taken
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/urhr_dp.sv
module urhr_dp #(
    parameter int LEVELS     = 16,
    parameter int SNAP_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  urhr_pkg::t_cmd                      i_cmd,
    input  logic [urhr_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [urhr_pkg::SNAP_FIELD_W-1:0]   i_snapshot_in,
    output logic                                o_accepted,
    output logic [urhr_pkg::SNAP_FIELD_W-1:0]   o_snapshot_out,
    output logic [urhr_pkg::COUNT_W-1:0]        o_undo_count,
    output logic [urhr_pkg::COUNT_W-1:0]        o_redo_count
);

    localparam int SW   = (SNAP_WIDTH < urhr_pkg::SNAP_FIELD_W) ?
                          SNAP_WIDTH : urhr_pkg::SNAP_FIELD_W;
    localparam int IW   = $clog2(LEVELS);
    localparam int CW   = $clog2(LEVELS + 1);
    localparam int SUMW = CW + 1;

    logic [SW-1:0]                    mem [LEVELS];
    logic [SW-1:0]                    r_rd_data;
    urhr_pkg::t_opcode                r_op;
    logic [SW-1:0]                    r_snap;
    logic [IW-1:0]                    r_oldest;
    logic [CW-1:0]                    r_undo;
    logic [CW-1:0]                    r_redo;

    logic                             r_out_ok;
    logic [urhr_pkg::SNAP_FIELD_W-1:0] r_out_snap;
    logic [urhr_pkg::COUNT_W-1:0]     r_out_undo;
    logic [urhr_pkg::COUNT_W-1:0]     r_out_redo;

    logic [CW-1:0]                    offset;
    logic [SUMW-1:0]                  sum;
    logic [IW-1:0]                    pos;
    logic                             do_ok;
    logic                             ring_full;
    logic [IW-1:0]                    n_oldest;
    logic [CW-1:0]                    n_undo;
    logic [CW-1:0]                    n_redo;
    logic [SW-1:0]                    result;
    logic [SW+urhr_pkg::SNAP_FIELD_W-1:0] result_wide;
    logic [CW+urhr_pkg::COUNT_W-1:0]  undo_wide;
    logic [CW+urhr_pkg::COUNT_W-1:0]  redo_wide;

    assign ring_full = (r_undo == CW'(LEVELS));

    // Pick the slot offset from the oldest entry and decide whether the op runs
    always_comb begin
        offset = r_undo;
        do_ok  = 1'b0;
        priority if (r_op == urhr_pkg::OP_PUSH) begin
            do_ok = 1'b1;
        end else if (r_op == urhr_pkg::OP_UNDO) begin
            offset = r_undo - 1'b1;
            do_ok  = (r_undo != '0);
        end else if (r_op == urhr_pkg::OP_REDO) begin
            do_ok = (r_redo != '0);
        end else begin
            do_ok = 1'b0;
        end
    end

    // Wrap the slot position modulo the ring depth
    assign sum = SUMW'(r_oldest) + SUMW'(offset);
    assign pos = (sum >= SUMW'(LEVELS)) ? IW'(sum - SUMW'(LEVELS)) : IW'(sum);

    // Next ring pointers and counts
    always_comb begin
        n_oldest = r_oldest;
        n_undo   = r_undo;
        n_redo   = r_redo;
        if (do_ok) begin
            priority if (r_op == urhr_pkg::OP_PUSH) begin
                n_redo = '0;
                if (ring_full) begin
                    n_oldest = (r_oldest == IW'(LEVELS - 1)) ? '0 : r_oldest + 1'b1;
                end else begin
                    n_undo = r_undo + 1'b1;
                end
            end else if (r_op == urhr_pkg::OP_UNDO) begin
                n_undo = r_undo - 1'b1;
                n_redo = r_redo + 1'b1;
            end else begin
                n_undo = r_undo + 1'b1;
                n_redo = r_redo - 1'b1;
            end
        end
    end

    // Swapped-out entry for undo and redo, else echo the presented word
    assign result      = (do_ok && (r_op != urhr_pkg::OP_PUSH)) ? r_rd_data : r_snap;
    assign result_wide = {{urhr_pkg::SNAP_FIELD_W{1'b0}}, result};
    assign undo_wide   = {{urhr_pkg::COUNT_W{1'b0}}, n_undo};
    assign redo_wide   = {{urhr_pkg::COUNT_W{1'b0}}, n_redo};

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_snap <= i_snapshot_in[SW-1:0];
        end
    end

    // Slot store: read the target slot, then write the presented word back
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= mem[pos];
        end
        if (i_cmd.commit && do_ok) begin
            mem[pos] <= r_snap;
        end
    end

    // Advance the ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_undo   <= '0;
            r_redo   <= '0;
        end else if (i_cmd.commit) begin
            r_oldest <= n_oldest;
            r_undo   <= n_undo;
            r_redo   <= n_redo;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_ok   <= do_ok;
            r_out_snap <= result_wide[urhr_pkg::SNAP_FIELD_W-1:0];
            r_out_undo <= undo_wide[urhr_pkg::COUNT_W-1:0];
            r_out_redo <= redo_wide[urhr_pkg::COUNT_W-1:0];
        end
    end

    assign o_accepted     = r_out_ok;
    assign o_snapshot_out = r_out_snap;
    assign o_undo_count   = r_out_undo;
    assign o_redo_count   = r_out_redo;

endmodule

// File: rtl/undo_redo_history_ring.sv
// Undo/redo history ring over a single-port slot store.
// The result word is offered after the slot read (ST_READ) and the commit (ST_FIN) steps.
// One word at a time: the next word is taken only once its read-then-write pass on the slot store commits.
// A pending result stalls the commit step until the output word is taken.
// Reset (synchronous, active low) empties both histories; slot contents stay undefined.
module undo_redo_history_ring #(
    parameter int LEVELS     = 16,
    parameter int SNAP_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    urhr_req_if.sink          i_req,
    urhr_rsp_if.source        o_rsp
);

    urhr_pkg::t_cmd cmd;

    urhr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    urhr_dp #(
        .LEVELS     (LEVELS),
        .SNAP_WIDTH (SNAP_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_req.opcode),
        .i_snapshot_in  (i_req.snapshot_in),
        .o_accepted     (o_rsp.accepted),
        .o_snapshot_out (o_rsp.snapshot_out),
        .o_undo_count   (o_rsp.undo_count),
        .o_redo_count   (o_rsp.redo_count)
    );

    // Only one word is in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input taken while a word is in flight");

    // A result never shows up in the cycle right after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !$rose(o_rsp.valid))
        else $error("result appeared before slot read completed");

    // Both histories together never exceed the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((LEVELS > 31) ||
            ({1'b0, o_rsp.undo_count} + {1'b0, o_rsp.redo_count} <= LEVELS)))
        else $error("undo plus redo count exceeds ring depth");

endmodule

// File: sim/testbench.sv
module testbench;

    localparam int HIST_LEVELS    = 16;
    localparam int POS_W          = $clog2(HIST_LEVELS);
    localparam int HOLDOFF_CYCLES = 150;
    localparam int DRAIN_SLACK    = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    // Opcode value with no operation behind it
    localparam urhr_pkg::t_opcode OP_UNUSED = 2'd3;

    typedef logic [urhr_pkg::SNAP_FIELD_W-1:0] t_snap;
    typedef logic [urhr_pkg::COUNT_W-1:0]      t_count;

    typedef struct packed {
        logic   accepted;
        t_snap  snapshot;
        t_count undo_cnt;
        t_count redo_cnt;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    urhr_req_if req_if ();
    urhr_rsp_if rsp_if ();

    undo_redo_history_ring #(
        .LEVELS     (HIST_LEVELS),
        .SNAP_WIDTH (urhr_pkg::SNAP_FIELD_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted history state
    t_snap            hist_slot [HIST_LEVELS];
    logic [POS_W-1:0] oldest_pos;
    int               undo_depth;
    int               redo_depth;

    t_outcome pending_outcomes[$];

    bit req_idle_en;
    bit rsp_idle_en;
    int rsp_holdoff;
    int mismatch_count;
    int idle_cycles;
    int op_seen [4];
    int refused_seen;
    int evictions_seen;
    int results_seen;
    int words_sent;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance the predicted history by one operation and return its result word
    function automatic t_outcome apply_history_op(urhr_pkg::t_opcode op, t_snap snap);
        t_outcome         res;
        logic [POS_W-1:0] pos;
        res.accepted = 1'b0;
        res.snapshot = snap;
        case (op)
            urhr_pkg::OP_PUSH: begin
                redo_depth = 0;
                if (undo_depth >= HIST_LEVELS) begin
                    oldest_pos = oldest_pos + 1'b1;
                    undo_depth = HIST_LEVELS - 1;
                    evictions_seen++;
                end
                pos = oldest_pos + POS_W'(undo_depth);
                hist_slot[pos] = snap;
                undo_depth++;
                res.accepted = 1'b1;
            end
            urhr_pkg::OP_UNDO: begin
                if (undo_depth > 0) begin
                    pos = oldest_pos + POS_W'(undo_depth - 1);
                    res.snapshot = hist_slot[pos];
                    hist_slot[pos] = snap;
                    undo_depth--;
                    redo_depth++;
                    res.accepted = 1'b1;
                end
            end
            urhr_pkg::OP_REDO: begin
                if (redo_depth > 0) begin
                    pos = oldest_pos + POS_W'(undo_depth);
                    res.snapshot = hist_slot[pos];
                    hist_slot[pos] = snap;
                    redo_depth--;
                    undo_depth++;
                    res.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        res.undo_cnt = t_count'(undo_depth);
        res.redo_cnt = t_count'(redo_depth);
        return res;
    endfunction

    task automatic report_field(input string name, input t_snap want, input t_snap got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Predict on every accepted request word, compare every accepted result word
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (pending_outcomes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h %h %0d %0d",
                             $time, rsp_if.accepted, rsp_if.snapshot_out,
                             rsp_if.undo_count, rsp_if.redo_count);
                end else begin
                    want = pending_outcomes.pop_front();
                    report_field("accepted", t_snap'(want.accepted), t_snap'(rsp_if.accepted));
                    report_field("snapshot_out", want.snapshot, rsp_if.snapshot_out);
                    report_field("undo_count", t_snap'(want.undo_cnt),
                                 t_snap'(rsp_if.undo_count));
                    report_field("redo_count", t_snap'(want.redo_cnt),
                                 t_snap'(rsp_if.redo_count));
                end
            end
            if (req_if.valid && req_if.ready) begin
                want = apply_history_op(req_if.opcode, req_if.snapshot_in);
                op_seen[req_if.opcode]++;
                if (!want.accepted)
                    refused_seen++;
                pending_outcomes.push_back(want);
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: long hold-off on request, random stall bursts, else take every word
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_holdoff > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (rsp_holdoff) @(posedge i_clk);
                rsp_holdoff = 0;
            end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Offer one request word, with an optional idle burst first; hold until taken
    task automatic send_word(input urhr_pkg::t_opcode op, input t_snap snap);
        if (req_idle_en && $urandom_range(0, 3) == 0) begin
            req_if.valid       <= 1'b0;
            req_if.opcode      <= urhr_pkg::t_opcode'($urandom);
            req_if.snapshot_in <= $urandom;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.snapshot_in <= snap;
        do @(posedge i_clk); while (!req_if.ready);
        words_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (results_seen < words_sent) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic t_snap pick_snapshot();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_snap'(1) << $urandom_range(0, urhr_pkg::SNAP_FIELD_W - 1);
            3:       return ~(t_snap'(1) << $urandom_range(0, urhr_pkg::SNAP_FIELD_W - 1));
            default: return $urandom;
        endcase
    endfunction

    // Weighted opcode choice; the unused code keeps a weight of one
    function automatic urhr_pkg::t_opcode pick_opcode(int w_push, int w_undo, int w_redo);
        int r;
        r = $urandom_range(0, w_push + w_undo + w_redo);
        if (r < w_push)
            return urhr_pkg::OP_PUSH;
        if (r < w_push + w_undo)
            return urhr_pkg::OP_UNDO;
        if (r < w_push + w_undo + w_redo)
            return urhr_pkg::OP_REDO;
        return OP_UNUSED;
    endfunction

    // Refusals on an empty history, the unused code, extreme snapshots
    task automatic test_refusals_and_codes();
        send_word(urhr_pkg::OP_UNDO, 32'h1234_5678);
        send_word(urhr_pkg::OP_REDO, 32'h8765_4321);
        send_word(OP_UNUSED, '1);
        send_word(urhr_pkg::OP_PUSH, '0);
        send_word(urhr_pkg::OP_PUSH, '1);
        send_word(urhr_pkg::OP_UNDO, 32'h5555_5555);
        send_word(urhr_pkg::OP_REDO, 32'hAAAA_AAAA);
        send_word(urhr_pkg::OP_REDO, 32'h0F0F_0F0F);
        send_word(urhr_pkg::OP_UNDO, 32'hF0F0_F0F0);
        send_word(urhr_pkg::OP_PUSH, 32'hA5A5_A5A5);
        send_word(urhr_pkg::OP_REDO, 32'h0000_0001);
        send_word(OP_UNUSED, '0);
        send_word(urhr_pkg::OP_UNDO, 32'h8000_0000);
        wait_drained();
    endtask

    // Overfill the ring to evict, then walk back and forth across its whole depth
    task automatic test_ring_eviction();
        repeat (HIST_LEVELS + 4) send_word(urhr_pkg::OP_PUSH, pick_snapshot());
        repeat (HIST_LEVELS + 1) send_word(urhr_pkg::OP_UNDO, pick_snapshot());
        repeat (HIST_LEVELS + 1) send_word(urhr_pkg::OP_REDO, pick_snapshot());
        wait_drained();
    endtask

    // Hold off the result side while requests keep coming, so the input stalls
    task automatic test_backpressure();
        req_idle_en = 1'b0;
        rsp_holdoff = HOLDOFF_CYCLES;
        repeat (40) send_word(pick_opcode(5, 3, 2), pick_snapshot());
        wait_drained();
    endtask

    // Sessions of editing, rewinding and replaying with random idling per session
    task automatic test_random_sessions(input int words);
        int sent;
        int len;
        int mode;
        sent = 0;
        while (sent < words) begin
            mode        = $urandom_range(0, 3);
            len         = $urandom_range(8, 64);
            req_idle_en = ($urandom_range(0, 2) != 0);
            rsp_idle_en = ($urandom_range(0, 2) != 0);
            repeat (len) begin
                case (mode)
                    0:       send_word(pick_opcode(12, 3, 2), pick_snapshot());
                    1:       send_word(pick_opcode(2, 12, 4), pick_snapshot());
                    2:       send_word(pick_opcode(2, 4, 12), pick_snapshot());
                    default: send_word(pick_opcode(6, 5, 5), pick_snapshot());
                endcase
            end
            sent += len;
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_streaming(input int words);
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        repeat (words) send_word(pick_opcode(5, 4, 4), pick_snapshot());
        wait_drained();
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.opcode      <= urhr_pkg::OP_PUSH;
        req_if.snapshot_in <= '0;
        oldest_pos     = '0;
        undo_depth     = 0;
        redo_depth     = 0;
        req_idle_en    = 1'b1;
        rsp_idle_en    = 1'b1;
        rsp_holdoff    = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        refused_seen   = 0;
        evictions_seen = 0;
        results_seen   = 0;
        words_sent     = 0;
        op_seen        = '{default: 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_refusals_and_codes();
        test_ring_eviction();
        test_backpressure();
        test_random_sessions(1700);
        test_streaming(150);

        if (pending_outcomes.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d results never arrived, expected 0 left, actual %0d",
                     $time, pending_outcomes.size(), pending_outcomes.size());
        end
        $display("Covered %0d results: %0d push, %0d undo, %0d redo, %0d unused-code words",
                 results_seen, op_seen[urhr_pkg::OP_PUSH], op_seen[urhr_pkg::OP_UNDO],
                 op_seen[urhr_pkg::OP_REDO], op_seen[OP_UNUSED]);
        $display("%0d refused or ignored, %0d evictions of the oldest entry, %0d mismatches",
                 refused_seen, evictions_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
